FILE: src/itf_pkg.sv
// Shared widths, constants and the digit table of the integer to text formatter.
package itf_pkg;

    localparam int unsigned VAL_W       = 32;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned BASE_W      = 5;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned REM_W       = 4;
    localparam int unsigned STEP_W      = $clog2(VAL_W);
    localparam int unsigned S_TDATA_W   = 48;
    localparam int unsigned M_TDATA_W   = 16;

    localparam int unsigned MAX_WIDTH_DEF   = 64;
    localparam int unsigned DIGIT_SLOTS_DEF = 33;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Lower-case digit for a remainder of 0..15.
    function automatic logic [CHAR_W-1:0] itf_digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h61;
            4'd11:   c = 8'h62;
            4'd12:   c = 8'h63;
            4'd13:   c = 8'h64;
            4'd14:   c = 8'h65;
            4'd15:   c = 8'h66;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

endpackage

FILE: src/itf_div.sv
// Bit-serial restoring divider: 32-bit dividend by a base of up to 16, one bit a cycle.
module itf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [itf_pkg::VAL_W-1:0]     i_dividend,
    input  logic [itf_pkg::BASE_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [itf_pkg::VAL_W-1:0]     o_quot,
    output logic [itf_pkg::REM_W-1:0]     o_rem
);
    import itf_pkg::*;

    logic [VAL_W-1:0]  r_q;
    logic [REM_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [BASE_W-1:0] w_shift;
    logic              w_ge;
    logic [BASE_W-1:0] w_diff;

    // Bring down the next dividend bit and try one subtraction.
    always_comb begin
        w_shift = {r_rem, r_q[VAL_W-1]};
        w_ge    = (w_shift >= i_divisor);
        w_diff  = w_shift - i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[VAL_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: src/integer_to_text_formatter_top.sv
// Top level of the integer to text formatter: control, digit store and output register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------------------------
//  s       | in        | i_s_tvalid, o_s_tready | i_s_tdata: value, width, base, is_signed
//  m       | out       | o_m_tvalid, i_m_tready | o_m_tdata: char_code, length; o_m_tlast; o_m_tuser
//
//  Per request: each digit costs 32 steps of the bit-serial divider plus one write into the digit
//  store; each stored character is then read from the store and emitted, and each pad is emitted
//  directly. A bad base costs one error word.
//  Reset is synchronous and clears the control state only; the digit store is always written
//  before it is read and needs no clearing. A stalled output holds the word in the output register
//  and freezes the emitting states; a new request is taken as soon as the previous text is queued.
module integer_to_text_formatter_top #(
    parameter int unsigned MAX_WIDTH   = itf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] value, [38:32] width, [43:39] base, [44] is_signed, [47:45] zero
    input  logic [itf_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] char_code, [14:8] length, [15] zero
    output logic [itf_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_m_tlast,
    // [0] error
    output logic                              o_m_tuser
);
    import itf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int unsigned IDX_W = $clog2(DIGIT_SLOTS);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(DIGIT_SLOTS);
    localparam logic [LEN_W-1:0] MAX_W_C =
        (MAX_WIDTH > (2 ** LEN_W) - 1) ? LEN_W'((2 ** LEN_W) - 1) : LEN_W'(MAX_WIDTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ERR  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_SIGN = 8'b0000_1000,
        S_CALC = 8'b0001_0000,
        S_PAD  = 8'b0010_0000,
        S_RD   = 8'b0100_0000,
        S_DIG  = 8'b1000_0000
    } t_state;

    // Request fields.
    logic [VAL_W-1:0]  w_value;
    logic [LEN_W-1:0]  w_width;
    logic [BASE_W-1:0] w_base;
    logic              w_is_signed;
    logic              w_neg;
    logic              w_bad_base;
    logic              w_accept;

    assign w_value     = i_s_tdata[31:0];
    assign w_width     = i_s_tdata[38:32];
    assign w_base      = i_s_tdata[43:39];
    assign w_is_signed = i_s_tdata[44];
    assign w_neg       = w_is_signed & w_value[VAL_W-1];
    assign w_bad_base  = (w_base < BASE_MIN) || (w_base > BASE_HEX);

    // Control and counters.
    t_state            r_state, n_state;
    logic [BASE_W-1:0] r_base;
    logic              r_neg;
    logic [LEN_W-1:0]  r_width, n_width;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_pad, n_pad;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_emit, n_emit;

    // Output register.
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_err;
    logic [LEN_W-1:0]  r_out_len;

    logic              w_slot_free;
    logic              w_emit;
    logic [CHAR_W-1:0] w_emit_char;
    logic              w_emit_last;
    logic              w_emit_err;

    // Divider hookup.
    logic              w_div_start;
    logic [VAL_W-1:0]  w_div_dividend;
    logic              w_div_done;
    logic [VAL_W-1:0]  w_div_quot;
    logic [REM_W-1:0]  w_div_rem;

    // Digit store, least significant digit first, then the minus sign.
    logic [CHAR_W-1:0] r_store [DIGIT_SLOTS];
    logic [CHAR_W-1:0] r_rd_data;
    logic              w_wr_en;
    logic [CHAR_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [CNT_W-1:0]  w_rd_cnt;

    logic [LEN_W-1:0]  w_cnt_ext;
    logic [LEN_W-1:0]  w_total_calc;

    assign w_accept    = i_s_tvalid & o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_cnt_ext   = LEN_W'(r_cnt);
    assign w_total_calc = (r_width < w_cnt_ext) ? w_cnt_ext : r_width;
    assign w_rd_cnt    = r_cnt - CNT_W'(1);

    always_comb begin
        n_state        = r_state;
        n_width        = r_width;
        n_cnt          = r_cnt;
        n_pad          = r_pad;
        n_total        = r_total;
        n_emit         = r_emit;
        w_div_start    = 1'b0;
        w_div_dividend = w_div_quot;
        w_wr_en        = 1'b0;
        w_wr_data      = itf_digit_char(w_div_rem);
        w_rd_en        = 1'b0;
        w_emit         = 1'b0;
        w_emit_char    = CH_NONE;
        w_emit_last    = 1'b0;
        w_emit_err     = 1'b0;

        case (r_state)
            S_IDLE: begin
                w_div_dividend = w_neg ? (~w_value + VAL_W'(1)) : w_value;
                if (w_accept) begin
                    n_width = (w_width > MAX_W_C) ? MAX_W_C : w_width;
                    n_cnt   = '0;
                    n_emit  = '0;
                    if (w_bad_base) begin
                        n_state = S_ERR;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_ERR: begin
                if (w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    w_emit_err  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                // Store each remainder as it appears; restart on the quotient until it hits zero.
                if (w_div_done) begin
                    if (r_cnt < SLOTS_C) begin
                        w_wr_en = 1'b1;
                        n_cnt   = r_cnt + CNT_W'(1);
                    end
                    if (w_div_quot != '0) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                if (r_neg && (r_cnt < SLOTS_C)) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = CH_MINUS;
                    n_cnt     = r_cnt + CNT_W'(1);
                end
                n_state = S_CALC;
            end
            S_CALC: begin
                n_total = w_total_calc;
                n_pad   = w_total_calc - w_cnt_ext;
                n_state = (w_total_calc != w_cnt_ext) ? S_PAD : S_RD;
            end
            S_PAD: begin
                if (w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = (r_base == BASE_HEX) ? CH_ZERO : CH_SPACE;
                    w_emit_last = ((r_emit + LEN_W'(1)) == r_total);
                    n_emit      = r_emit + LEN_W'(1);
                    n_pad       = r_pad - LEN_W'(1);
                    if (r_pad == LEN_W'(1)) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_DIG;
            end
            S_DIG: begin
                if (w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = r_rd_data;
                    w_emit_last = ((r_emit + LEN_W'(1)) == r_total);
                    n_emit      = r_emit + LEN_W'(1);
                    n_cnt       = r_cnt - CNT_W'(1);
                    n_state     = (r_cnt == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pad       <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pad   <= n_pad;
            r_emit  <= n_emit;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_total <= n_total;
        if (w_accept) begin
            r_base <= w_base;
            r_neg  <= w_neg;
        end
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
            r_out_err  <= w_emit_err;
            r_out_len  <= (w_emit_last && !w_emit_err) ? r_total : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[r_cnt[IDX_W-1:0]] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[w_rd_cnt[IDX_W-1:0]];
        end
    end

    itf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_accept ? w_base : r_base),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_len, r_out_char};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

endmodule

FILE: src/itf_chk.sv
// Port-level checker for the integer to text formatter, bound to the top level.
module itf_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [itf_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [itf_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input logic                              o_m_tlast,
    input logic                              o_m_tuser
);
    import itf_pkg::*;

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // An error word is a single NUL character with last set and no length.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata == '0))
        else $error("malformed error word");

    // Only the final character carries the length.
    a_len_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> (o_m_tdata[14:8] == '0))
        else $error("length on a non-final character");

    // Text always has at least one character, so the final length is nonzero.
    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && !o_m_tuser |-> (o_m_tdata[14:8] != '0))
        else $error("zero length on final character");

    // Drop the output word on reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind integer_to_text_formatter_top itf_chk u_itf_chk (.*);
